// ===== sv/chc_pkg.sv =====
// ----------------------------------------------------------------------------
// chc_pkg - shared types and constants
// Item layout that flows along the bucket cell chain, opcodes, selector codes
// and the reset values of the bucket limits.
// ----------------------------------------------------------------------------
package chc_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int VALUE_W     = 64;
    localparam int SEL_W       = 4;
    localparam int CFG_INDEX_W = 4;
    localparam int MAX_BUCKETS = 8;

    // opcodes
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // selector codes beyond the bucket range
    localparam logic [SEL_W-1:0] SEL_TOTAL = 4'd8;
    localparam logic [SEL_W-1:0] SEL_SUM   = 4'd9;

    // limit reset values, signed Q16.16
    localparam logic [SAMPLE_W-1:0] LIMIT_RESET [MAX_BUCKETS] = '{
        32'd328, 32'd655, 32'd1638, 32'd3277,
        32'd6554, 32'd16384, 32'd32768, 32'd65536
    };

    // one item in flight along the chain
    typedef struct packed {
        logic                valid;
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic [SEL_W-1:0]    sel;
        logic                go;      // scan still running downward
        logic [VALUE_W-1:0]  value;   // read result gathered on the way
    } chc_item_t;

endpackage

// ===== sv/chc_head.sv =====
// ----------------------------------------------------------------------------
// chc_head - entry stage
// Keeps the total count and the running sum, captures the incoming item and
// starts the downward bucket scan.
// ----------------------------------------------------------------------------
module chc_head
    import chc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                in_valid,
    input  logic                in_op,
    input  logic [SAMPLE_W-1:0] in_sample,
    input  logic [SEL_W-1:0]    in_sel,
    output chc_item_t           item_out
);

    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] total_next;
    logic [VALUE_W-1:0]     sum_reg;
    logic [VALUE_W-1:0]     sum_next;
    chc_item_t              item_reg;
    chc_item_t              item_next;
    logic                   observe;

    assign observe = advance && in_valid && (in_op == OP_OBSERVE);

    // update total and sum on an observe
    always_comb begin
        total_next = total_reg;
        sum_next   = sum_reg;
        if (observe) begin
            total_next = total_reg + COUNT_WIDTH'(1);
            sum_next   = sum_reg + VALUE_W'($signed(in_sample));
        end
    end

    // form the item; reads of total or sum pick their value here
    always_comb begin
        item_next        = '0;
        item_next.valid  = in_valid;
        item_next.op     = in_op;
        item_next.sample = in_sample;
        item_next.sel    = in_sel;
        item_next.go     = 1'b1;
        case (in_sel)
            SEL_TOTAL: item_next.value = VALUE_W'(total_reg);
            SEL_SUM:   item_next.value = sum_reg;
            default:   item_next.value = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg      <= '0;
            sum_reg        <= '0;
            item_reg.valid <= 1'b0;
        end else begin
            total_reg <= total_next;
            sum_reg   <= sum_next;
            if (advance) begin
                item_reg <= item_next;
            end
        end
    end

    assign item_out = item_reg;

endmodule

// ===== sv/chc_cell.sv =====
// ----------------------------------------------------------------------------
// chc_cell - one bucket of the chain
// Holds one limit and one bucket count. An observe bumps the count while the
// scan is still running and the sample is at or below the limit; a read of
// this bucket picks up the count. The item moves on to the next cell.
// ----------------------------------------------------------------------------
module chc_cell
    import chc_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]    cfg_data,
    input  chc_item_t              item_in,
    output chc_item_t              item_out
);

    logic [SAMPLE_W-1:0]    limit_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    chc_item_t              item_reg;
    chc_item_t              item_next;
    logic                   in_range;
    logic                   hit;

    assign in_range = $signed(item_in.sample) <= $signed(limit_reg);
    assign hit      = item_in.valid && (item_in.op == OP_OBSERVE)
                      && item_in.go && in_range;

    // bump the count and carry the scan onward
    always_comb begin
        count_next = count_reg;
        item_next  = item_in;
        if (advance && hit) begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        item_next.go = item_in.go && in_range;
        if (item_in.sel == SEL_W'(IDX)) begin
            item_next.value = VALUE_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg      <= LIMIT_RESET[IDX];
            count_reg      <= '0;
            item_reg.valid <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cfg_we && (cfg_index == CFG_INDEX_W'(IDX))) begin
                limit_reg <= cfg_data;
            end
            if (advance) begin
                item_reg <= item_next;
            end
        end
    end

    assign item_out = item_reg;

endmodule

// ===== sv/cumulative_histogram_counter_top.sv =====
// ----------------------------------------------------------------------------
// Path: a read item accepted at the input is registered in the head stage, then
// in each bucket cell in turn, before its result is valid.
// Throughput: one item per cycle; the chain of bucket cells and the output
// register advance together and hold only while a result waits on m_tready.
// Reset: synchronous, active low; clears all counts, the sum and the item
// valid flags, and loads the default limits.
// ----------------------------------------------------------------------------
// cumulative_histogram_counter_top - cumulative bucket histogram
// Observe items add to the sum and count and walk the bucket cells from the
// top bucket down; read items collect one bucket count, the total or the sum
// (zero for an unused selector) on the way and come out as a result.
// ----------------------------------------------------------------------------
module cumulative_histogram_counter_top
    import chc_pkg::*;
#(
    parameter int NUM_BUCKETS = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [31:0] sample
    input  logic [4:0]             s_tuser,   // [0] opcode, [4:1] read_select
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,   // [63:0] read_value
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]    cfg_data
);

    chc_item_t items [NUM_BUCKETS+1];
    logic      advance;
    logic      cfg_we;
    chc_item_t last_item;

    assign last_item = items[NUM_BUCKETS];

    // the whole chain moves unless a result is stalled at the output
    assign m_tvalid  = last_item.valid && (last_item.op == OP_READ);
    assign m_tdata   = last_item.value;
    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    chc_head #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_head (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser[0]),
        .in_sample (s_tdata),
        .in_sel    (s_tuser[4:1]),
        .item_out  (items[0])
    );

    // cell k serves bucket NUM_BUCKETS-1-k: the scan runs from the top down
    for (genvar k = 0; k < NUM_BUCKETS; k++) begin : g_cell
        chc_cell #(
            .IDX         (NUM_BUCKETS - 1 - k),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .cfg_we    (cfg_we),
            .cfg_index (cfg_index),
            .cfg_data  (cfg_data),
            .item_in   (items[k]),
            .item_out  (items[k+1])
        );
    end

endmodule

// ===== sim/cumulative_histogram_counter_top_tb.sv =====
// ----------------------------------------------------------------------------
// cumulative_histogram_counter_top_tb - self-checking bench for the histogram
// Streams observe and read items through the block under several limit
// settings and flow-control patterns. A bench-side histogram tracks the sum,
// the total and the bucket tallies, and every read result is compared with
// the value that histogram held when the read item was accepted.
// ----------------------------------------------------------------------------
module cumulative_histogram_counter_top_tb;
    import chc_pkg::*;

    localparam int NB            = 8;
    localparam int COUNT_W       = 32;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = NB + 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [SAMPLE_W-1:0] Q16_MIN = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] Q16_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic [SEL_W-1:0]    sel;
    } hist_item_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata   = '0;
    logic [4:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [63:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0]    cfg_data  = '0;

    // bench-side histogram
    logic signed [SAMPLE_W-1:0] limit_q16 [NB];
    logic [COUNT_W-1:0]         bucket_tally [NB];
    logic [COUNT_W-1:0]         total_tally;
    logic [VALUE_W-1:0]         sum_q48;

    hist_item_t         pending_items [$];
    logic [VALUE_W-1:0] expected_reads [$];
    hist_item_t         offered_item;

    int tx_idle_pct      = 0;
    int rx_stall_pct     = 0;
    int rx_hold_requests = 0;
    int rx_hold_served   = 0;
    int rx_hold_left     = 0;
    int errors           = 0;
    int stall_cycles;

    cumulative_histogram_counter_top #(
        .NUM_BUCKETS(NB),
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Apply one accepted item to the histogram; queue the value a read returns.
    function automatic void tally_item(hist_item_t item);
        bit scanning;
        scanning = 1'b1;
        if (item.op == OP_OBSERVE) begin
            sum_q48     += {{(VALUE_W-SAMPLE_W){item.sample[SAMPLE_W-1]}}, item.sample};
            total_tally += 1'b1;
            // walk down from the top bucket, stop at the first exceeded limit
            for (int i = NB - 1; i >= 0; i--) begin
                if ($signed(item.sample) > limit_q16[i])
                    scanning = 1'b0;
                if (scanning)
                    bucket_tally[i] += 1'b1;
            end
        end else if (item.sel < NB) begin
            expected_reads.push_back(VALUE_W'(bucket_tally[item.sel[2:0]]));
        end else if (item.sel == SEL_TOTAL) begin
            expected_reads.push_back(VALUE_W'(total_tally));
        end else if (item.sel == SEL_SUM) begin
            expected_reads.push_back(sum_q48);
        end else begin
            expected_reads.push_back('0);
        end
    endfunction

    // Driver: offer pending items, tally each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                tally_item(offered_item);
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    offered_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered_item.sample;
                    s_tuser  <= {offered_item.sel, offered_item.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result, then drive the receiver's ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: unexpected read_value: expected none, got %h",
                             $time, m_tdata);
                    errors++;
                end else if (m_tdata !== expected_reads[0]) begin
                    $display("%0t: read_value mismatch: expected %h, got %h",
                             $time, expected_reads[0], m_tdata);
                    errors++;
                    void'(expected_reads.pop_front());
                end else begin
                    void'(expected_reads.pop_front());
                end
            end
            // start a long hold-off when one is requested
            if (rx_hold_served != rx_hold_requests) begin
                rx_hold_served = rx_hold_requests;
                rx_hold_left   = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("cumulative_histogram_counter_top_tb failed");
        $finish;
    end

    task automatic push_item(input logic op, input logic [SAMPLE_W-1:0] sample,
                             input logic [SEL_W-1:0] sel);
        hist_item_t item;
        item.op     = op;
        item.sample = sample;
        item.sel    = sel;
        pending_items.push_back(item);
    endtask

    // Write one register while the block is idle.
    task automatic write_config(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [SAMPLE_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < NB)
            limit_q16[idx[2:0]] = value;
        cfg_valid <= 1'b0;
    endtask

    // Hold until every item is in and every result is out, then let the
    // chain flush trailing observes.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_reads.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Samples cluster on limits and extremes so that every scan depth shows up.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(5))
            0: v = $urandom();
            1: v = limit_q16[3'($urandom_range(NB - 1))] + SAMPLE_W'($urandom_range(4))
                   - 32'd2;
            2: v = Q16_MIN;
            3: v = Q16_MAX;
            4: v = $urandom_range(70000);
            default: v = -SAMPLE_W'($urandom_range(70000));
        endcase
        return v;
    endfunction

    task automatic queue_random(input int count);
        logic               op;
        logic [SEL_W-1:0]   sel;
        for (int n = 0; n < count; n++) begin
            op  = ($urandom_range(99) < 40) ? OP_READ : OP_OBSERVE;
            sel = ($urandom_range(99) < 85) ? SEL_W'($urandom_range(SEL_SUM))
                                            : SEL_W'($urandom_range(15));
            push_item(op, pick_sample(), sel);
        end
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        @(negedge aclk);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    initial begin
        int bounds [$];

        for (int i = 0; i < NB; i++) begin
            limit_q16[i]    = LIMIT_RESET[i];
            bucket_tally[i] = '0;
        end
        total_tally = '0;
        sum_q48     = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty counters, extreme samples, samples on and just past
        // a limit, then every selector including the unused ones.
        @(negedge aclk);
        push_item(OP_READ, 32'h0, SEL_TOTAL);
        push_item(OP_READ, 32'hFFFF_FFFF, SEL_SUM);
        push_item(OP_OBSERVE, Q16_MIN, 4'hF);
        push_item(OP_OBSERVE, Q16_MAX, '0);
        push_item(OP_OBSERVE, 32'h0, SEL_SUM);
        push_item(OP_OBSERVE, LIMIT_RESET[0], '0);
        push_item(OP_OBSERVE, LIMIT_RESET[0] + 1, '0);
        push_item(OP_OBSERVE, LIMIT_RESET[NB-1], '0);
        push_item(OP_OBSERVE, LIMIT_RESET[NB-1] + 1, '0);
        push_item(OP_OBSERVE, 32'hFFFF_FFFF, '0);
        for (int s = 0; s < 16; s++)
            push_item(OP_READ, (s % 2) ? 32'hFFFF_FFFF : 32'h0, SEL_W'(s));
        wait_drained();

        // Unsorted limits, plus writes past the last limit that must be ignored.
        for (int i = 0; i < NB; i++)
            write_config(CFG_INDEX_W'(i), SAMPLE_W'(70000 - i * 9000));
        for (int idx = NB; idx < 16; idx++)
            write_config(CFG_INDEX_W'(idx), $urandom());
        queue_random(200);
        wait_drained();

        // Extreme limits; sender idles half the time.
        for (int i = 0; i < NB; i++)
            write_config(CFG_INDEX_W'(i), (i < NB / 2) ? Q16_MIN : Q16_MAX);
        set_idling(53, 0);
        queue_random(200);
        wait_drained();

        // Sorted random limits; receiver stalls, with one long hold-off that
        // backs the chain up while the sender keeps offering.
        for (int i = 0; i < NB; i++)
            bounds.push_back(int'($urandom_range(140000)) - 70000);
        bounds.sort();
        for (int i = 0; i < NB; i++)
            write_config(CFG_INDEX_W'(i), SAMPLE_W'(bounds[i]));
        set_idling(0, 53);
        queue_random(250);
        @(negedge aclk);
        rx_hold_requests++;
        wait_drained();

        // Default limits again; both sides idle.
        for (int i = 0; i < NB; i++)
            write_config(CFG_INDEX_W'(i), LIMIT_RESET[i]);
        set_idling(32, 32);
        queue_random(250);
        wait_drained();

        // Fully random limits, full rate.
        for (int i = 0; i < NB; i++)
            write_config(CFG_INDEX_W'(i), $urandom());
        set_idling(0, 0);
        queue_random(200);
        wait_drained();

        if (expected_reads.size() != 0)
            errors++;
        if (errors == 0)
            $display("cumulative_histogram_counter_top_tb passed");
        else
            $display("cumulative_histogram_counter_top_tb failed");
        $finish;
    end

endmodule
